// File: rtl/core/kbfe_pkg.sv
// Package for the separable basis field evaluator.
// Holds sizes, function codes, state encoding and controller/datapath command types.
package kbfe_pkg;
    localparam int MAX_SIZE   = 64;
    localparam int MAX_ORDER  = 16;
    localparam int ROW_W      = $clog2(MAX_SIZE);
    localparam int ORD_W      = $clog2(MAX_ORDER);
    localparam int BASIS_DEPTH = MAX_SIZE * MAX_ORDER;
    localparam int COEF_DEPTH  = MAX_ORDER * MAX_ORDER * MAX_ORDER;
    localparam int BA_W       = $clog2(BASIS_DEPTH);
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int CNT_W      = ORD_W + 1;

    localparam logic [2:0] FUNC_LOAD_X = 3'd0;
    localparam logic [2:0] FUNC_LOAD_Y = 3'd1;
    localparam logic [2:0] FUNC_LOAD_Z = 3'd2;
    localparam logic [2:0] FUNC_LOAD_C = 3'd3;
    localparam logic [2:0] FUNC_EVAL   = 3'd4;

    localparam logic [1:0] CFG_ORDER_X = 2'd0;
    localparam logic [1:0] CFG_ORDER_Y = 2'd1;
    localparam logic [1:0] CFG_ORDER_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_DRAIN, ST_FINISH, ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic           clear;      // start of evaluation
        logic           rd;         // issue a read of one triple
        logic [ORD_W-1:0] i;
        logic [ORD_W-1:0] j;
        logic [ORD_W-1:0] k;
        logic [CA_W-1:0]  caddr;
        logic           finish;     // saturate sum into output register
        logic           zero;       // give a zero result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;                 // pipeline still holds terms
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                                 output logic clip);
        clip = 1'b0;
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage

// File: rtl/core/kbfe_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module kbfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/kbfe_ctrl.sv
// Controller: request handshake, loop counters over (k, j, i), result handshake.
// Depends on kbfe_pkg.
module kbfe_ctrl import kbfe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_oob,
    input  logic [CNT_W-1:0]     i_ox,
    input  logic [CNT_W-1:0]     i_oy,
    input  logic [CNT_W-1:0]     i_oz,
    input  t_status              i_status,
    input  logic                 i_out_ready,
    output logic                 o_idle,
    output logic                 o_out_valid,
    output t_cmd                 o_cmd
);
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CA_W-1:0]  r_ca, n_ca;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i <= '0; r_j <= '0; r_k <= '0; r_ca <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i; r_j <= n_j; r_k <= n_k; r_ca <= n_ca;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_k = r_k; n_ca = r_ca;
        o_cmd = '0;
        o_cmd.i = r_i[ORD_W-1:0];
        o_cmd.j = r_j[ORD_W-1:0];
        o_cmd.k = r_k[ORD_W-1:0];
        o_cmd.caddr = r_ca;
        o_idle = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_i = '0; n_j = '0; n_k = '0; n_ca = '0;
                    if (i_oob || i_ox == '0 || i_oy == '0 || i_oz == '0) begin
                        o_cmd.zero = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                o_cmd.rd = 1'b1;
                n_ca = r_ca + CA_W'(1);
                if (r_i + CNT_W'(1) < i_ox) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_i = '0;
                    if (r_j + CNT_W'(1) < i_oy) begin
                        n_j = r_j + CNT_W'(1);
                    end else begin
                        n_j = '0;
                        if (r_k + CNT_W'(1) < i_oz) begin
                            n_k = r_k + CNT_W'(1);
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: rtl/core/kbfe_dp.sv
// Datapath: basis and coefficient RAMs, shared product chain, 64-bit accumulator.
// Depends on kbfe_pkg and kbfe_ram.
module kbfe_dp import kbfe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [2:0]           i_func,
    input  logic [5:0]           i_row,
    input  logic [3:0]           i_col,
    input  logic [11:0]          i_cidx,
    input  logic signed [31:0]   i_value,
    input  logic [5:0]           i_vx,
    input  logic [5:0]           i_vy,
    input  logic [5:0]           i_vz,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic signed [31:0]   o_field,
    output logic                 o_sat
);
    logic [ROW_W-1:0] r_vx, r_vy, r_vz;
    logic row_ok, col_ok, cidx_ok;
    logic [BA_W-1:0] w_addr;
    logic [BA_W-1:0] ra_x, ra_y, ra_z;
    logic [31:0] d_x, d_y, d_z, d_c;

    assign row_ok  = 32'(i_row) < MAX_SIZE;
    assign col_ok  = 32'(i_col) < MAX_ORDER;
    assign cidx_ok = 32'(i_cidx) < COEF_DEPTH;
    assign w_addr  = BA_W'(i_row[ROW_W-1:0]) * BA_W'(MAX_ORDER) + BA_W'(i_col[ORD_W-1:0]);
    assign ra_x = BA_W'(r_vx) * BA_W'(MAX_ORDER) + BA_W'(i_cmd.i);
    assign ra_y = BA_W'(r_vy) * BA_W'(MAX_ORDER) + BA_W'(i_cmd.j);
    assign ra_z = BA_W'(r_vz) * BA_W'(MAX_ORDER) + BA_W'(i_cmd.k);

    kbfe_ram #(.WIDTH(32), .DEPTH(BASIS_DEPTH)) u_ram_x (
        .i_clk, .i_we(i_load && i_func == FUNC_LOAD_X && row_ok && col_ok),
        .i_waddr(w_addr), .i_wdata(i_value), .i_raddr(ra_x), .o_rdata(d_x));
    kbfe_ram #(.WIDTH(32), .DEPTH(BASIS_DEPTH)) u_ram_y (
        .i_clk, .i_we(i_load && i_func == FUNC_LOAD_Y && row_ok && col_ok),
        .i_waddr(w_addr), .i_wdata(i_value), .i_raddr(ra_y), .o_rdata(d_y));
    kbfe_ram #(.WIDTH(32), .DEPTH(BASIS_DEPTH)) u_ram_z (
        .i_clk, .i_we(i_load && i_func == FUNC_LOAD_Z && row_ok && col_ok),
        .i_waddr(w_addr), .i_wdata(i_value), .i_raddr(ra_z), .o_rdata(d_z));
    kbfe_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_ram_c (
        .i_clk, .i_we(i_load && i_func == FUNC_LOAD_C && cidx_ok),
        .i_waddr(i_cidx[CA_W-1:0]), .i_wdata(i_value), .i_raddr(i_cmd.caddr),
        .o_rdata(d_c));

    // pipeline: s0 RAM read, s1 A*B, s2 round, s3 *C, s4 round, s5 *coef, s6 round+acc
    logic [6:0] r_v;
    logic signed [31:0] r_c1, r_c2, r_cf1, r_cf2, r_cf3, r_cf4;
    logic signed [63:0] r_p1, r_p2, r_p3;
    logic signed [31:0] r_t1, r_t2;
    logic r_clip1, r_clip2, r_clip3, r_clip4;
    logic signed [63:0] r_acc;
    logic r_sacc;
    logic signed [31:0] r_field;
    logic r_sat;
    logic signed [31:0] t1, t2, t3, sfin;
    logic c1, c2, c3, cfin;
    logic signed [63:0] rnd1, rnd2, rnd3;

    assign rnd1 = (r_p1 + 64'sd32768) >>> 16;
    assign rnd2 = (r_p2 + 64'sd32768) >>> 16;
    assign rnd3 = (r_p3 + 64'sd32768) >>> 16;
    always_comb begin
        t1 = sat32(rnd1, c1);
        t2 = sat32(rnd2, c2);
        t3 = sat32(rnd3, c3);
        sfin = sat32(r_acc, cfin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_cmd.rd};
        end
        if (i_cmd.clear) begin
            r_vx <= i_vx[ROW_W-1:0];
            r_vy <= i_vy[ROW_W-1:0];
            r_vz <= i_vz[ROW_W-1:0];
            r_acc <= '0;
            r_sacc <= 1'b0;
        end
        // stage 1
        r_p1 <= $signed(d_x) * $signed(d_y);
        r_c1 <= d_z;
        r_cf1 <= d_c;
        // stage 2
        r_t1 <= t1; r_clip1 <= c1 && r_v[1];
        r_c2 <= r_c1; r_cf2 <= r_cf1;
        // stage 3: carry the flag along with its term
        r_p2 <= r_t1 * r_c2;
        r_cf3 <= r_cf2;
        r_clip2 <= r_clip1;
        // stage 4
        r_t2 <= t2; r_clip3 <= r_clip2 || (c2 && r_v[3]);
        r_cf4 <= r_cf3;
        // stage 5
        r_p3 <= r_t2 * r_cf4;
        r_clip4 <= r_clip3;
        // stage 6: accumulate
        if (!i_cmd.clear && r_v[5]) begin
            r_acc <= r_acc + 64'(t3);
            r_sacc <= r_sacc || r_clip4 || c3;
        end
        if (i_cmd.zero) begin
            r_field <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.finish) begin
            r_field <= sfin;
            r_sat <= r_sacc || cfin;
        end
    end

    assign o_status.busy = |r_v;
    assign o_field = r_field;
    assign o_sat = r_sat;
endmodule

// File: rtl/core/kronecker_basis_field_eval.sv
// Top level of the separable basis field evaluator.
// Depends on kbfe_pkg, kbfe_ctrl and kbfe_dp.
//
// Input channel (i_valid/o_ready) takes one request per handshake: func 0..2
// write a basis element, func 3 a coefficient, func 4 evaluates a voxel.
// Loads are accepted while the block is idle and give no result. An evaluate request
// returns one result on o_valid/i_ready with field_value and saturated.
// Evaluation walks ox*oy*oz triples, one issued per cycle through a shared
// three-multiply chain of 7 stages; one evaluation is in flight at a time.
// Zero orders return 0 with the result valid in the cycle after the request.
// Order registers are written on i_cfg_we; the user is bound to write them
// only while the block is idle, which the block itself does not enforce;
// values above 16 act as 16. Reset (synchronous, active low) sets all orders
// to 1 and empties the result; memory contents are not cleared. While the
// receiver stalls the result holds and no new request is taken.
module kronecker_basis_field_eval import kbfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic [5:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic [11:0]        i_coef_index,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_voxel_x,
    input  logic [5:0]         i_voxel_y,
    input  logic [5:0]         i_voxel_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_field_value,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data
);
    logic [4:0] r_ox, r_oy, r_oz;
    logic [CNT_W-1:0] ox, oy, oz;
    logic idle, acc, oob;
    t_cmd cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= 5'd1; r_oy <= 5'd1; r_oz <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORDER_X: r_ox <= i_cfg_data;
                CFG_ORDER_Y: r_oy <= i_cfg_data;
                CFG_ORDER_Z: r_oz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp orders to the stored maximum
    assign ox = (32'(r_ox) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(r_ox);
    assign oy = (32'(r_oy) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(r_oy);
    assign oz = (32'(r_oz) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(r_oz);
    assign oob = 32'(i_voxel_x) >= MAX_SIZE || 32'(i_voxel_y) >= MAX_SIZE
              || 32'(i_voxel_z) >= MAX_SIZE;

    assign o_ready = idle;
    assign acc = i_valid && idle;

    kbfe_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(acc && i_func == FUNC_EVAL), .i_oob(oob),
        .i_ox(ox), .i_oy(oy), .i_oz(oz),
        .i_status(status), .i_out_ready(i_ready),
        .o_idle(idle), .o_out_valid(o_valid), .o_cmd(cmd));

    kbfe_dp u_dp (
        .i_clk, .i_rst_n,
        .i_load(acc), .i_func(i_func), .i_row(i_row_index), .i_col(i_col_index),
        .i_cidx(i_coef_index), .i_value(i_value),
        .i_vx(i_voxel_x), .i_vy(i_voxel_y), .i_vz(i_voxel_z),
        .i_cmd(cmd), .o_status(status),
        .o_field(o_field_value), .o_sat(o_saturated));
endmodule

// File: tb/tb_kronecker_basis_field_eval.sv
// Testbench for kronecker_basis_field_eval: loads basis matrices and coefficients,
// evaluates voxels under several order settings and checks each result field.
// Depends on kbfe_pkg and the RTL of kronecker_basis_field_eval.
module tb_kronecker_basis_field_eval;
    import kbfe_pkg::*;

    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int IDLE_LAT   = 16;
    localparam int STALL_LEN  = 400;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         row;
        logic [3:0]         col;
        logic [11:0]        cidx;
        logic signed [31:0] value;
        logic [5:0]         vx;
        logic [5:0]         vy;
        logic [5:0]         vz;
    } t_voxel_req;

    typedef struct packed {
        logic signed [31:0] field;
        logic               sat;
    } t_field_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic drv_valid = 1'b0;
    logic o_ready;
    t_voxel_req cur = '0;
    logic o_valid;
    logic rx_ready = 1'b0;
    logic signed [31:0] o_field_value;
    logic o_saturated;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [4:0] cfg_data = '0;

    kronecker_basis_field_eval u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(drv_valid), .o_ready(o_ready),
        .i_func(cur.func), .i_row_index(cur.row), .i_col_index(cur.col),
        .i_coef_index(cur.cidx), .i_value(cur.value),
        .i_voxel_x(cur.vx), .i_voxel_y(cur.vy), .i_voxel_z(cur.vz),
        .o_valid(o_valid), .i_ready(rx_ready),
        .o_field_value(o_field_value), .o_saturated(o_saturated),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state, updated as requests are accepted
    logic signed [31:0] bx_mem [BASIS_DEPTH];
    logic signed [31:0] by_mem [BASIS_DEPTH];
    logic signed [31:0] bz_mem [BASIS_DEPTH];
    logic signed [31:0] coef_mem [COEF_DEPTH];
    logic [4:0] ord_x = 5'd1, ord_y = 5'd1, ord_z = 5'd1;

    // written-entry tracking for stimulus generation
    bit wx [BASIS_DEPTH];
    bit wy [BASIS_DEPTH];
    bit wz [BASIS_DEPTH];
    bit wc [COEF_DEPTH];

    t_voxel_req pend_q[$];
    t_field_res field_q[$];
    int fail_cnt = 0;
    int n_evals = 0, n_loads = 0, n_sat = 0;
    logic in_fire = 1'b0, out_fire = 1'b0;
    int tx_gap = 0, rx_gap = 0;
    bit tx_burst = 0, rx_burst = 0;
    bit hold_go = 0, hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    function automatic int eff_ord(input logic [4:0] o);
        return (o > MAX_ORDER) ? MAX_ORDER : int'(o);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v, inout logic c);
        if (v > 64'sd2147483647) begin
            c = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            c = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Q16.16 multiply: exact product, round half up, floor shift, saturate
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  inout logic c);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = (p + 64'sd32768) >>> 16;
        return clip32(p, c);
    endfunction

    function automatic t_field_res eval_voxel(input t_voxel_req r);
        t_field_res res;
        logic signed [63:0] acc;
        logic signed [31:0] t;
        logic c;
        int ox, oy, oz;
        ox = eff_ord(ord_x);
        oy = eff_ord(ord_y);
        oz = eff_ord(ord_z);
        acc = 0;
        c = 1'b0;
        for (int k = 0; k < oz; k++)
            for (int j = 0; j < oy; j++)
                for (int i = 0; i < ox; i++) begin
                    t = fx_mul(bx_mem[r.vx*MAX_ORDER+i], by_mem[r.vy*MAX_ORDER+j], c);
                    t = fx_mul(t, bz_mem[r.vz*MAX_ORDER+k], c);
                    t = fx_mul(t, coef_mem[k*ox*oy + j*ox + i], c);
                    acc += 64'(t);
                end
        res.field = clip32(acc, c);
        res.sat = c;
        return res;
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1: return $signed($urandom);
            2: return $signed($urandom_range(0, 511)) - 256;
            default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff;
        endcase
    endfunction

    // accept, predict, and check at the rising edge
    always @(posedge i_clk) begin
        t_field_res exp_r;
        in_fire <= drv_valid && o_ready === 1'b1;
        out_fire <= i_rst_n && o_valid === 1'b1 && rx_ready;
        if (drv_valid && o_ready === 1'b1) begin
            case (cur.func)
                FUNC_LOAD_X: bx_mem[cur.row*MAX_ORDER+cur.col] = cur.value;
                FUNC_LOAD_Y: by_mem[cur.row*MAX_ORDER+cur.col] = cur.value;
                FUNC_LOAD_Z: bz_mem[cur.row*MAX_ORDER+cur.col] = cur.value;
                FUNC_LOAD_C: coef_mem[cur.cidx] = cur.value;
                FUNC_EVAL: begin
                    exp_r = eval_voxel(cur);
                    field_q.push_back(exp_r);
                    n_evals++;
                    if (exp_r.sat)
                        n_sat++;
                end
                default: ;
            endcase
            if (cur.func < FUNC_EVAL)
                n_loads++;
        end
        if (i_rst_n && o_valid === 1'b1 && rx_ready) begin
            if (field_q.size() == 0) begin
                $display("%0t: unexpected result field_value=%h saturated=%b",
                         $time, o_field_value, o_saturated);
                fail_cnt++;
            end else begin
                exp_r = field_q.pop_front();
                if (o_field_value !== exp_r.field) begin
                    $display("%0t: field_value expected %h actual %h",
                             $time, exp_r.field, o_field_value);
                    fail_cnt++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_r.sat, o_saturated);
                    fail_cnt++;
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!(drv_valid && !in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                drv_valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                cur <= pend_q.pop_front();
                drv_valid <= 1'b1;
                tx_gap <= draw_wait(tx_burst);
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // long receiver stall, counted on its own
    always @(negedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= STALL_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        int w;
        w = out_fire ? draw_wait(rx_burst) : rx_gap;
        if (w > 0) begin
            rx_gap <= w - 1;
            rx_ready <= 1'b0;
        end else begin
            rx_gap <= 0;
            rx_ready <= (hold_left == 0) && i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire || cfg_we || !i_rst_n || hold_left != 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_req(input t_voxel_req r);
        pend_q.push_back(r);
    endtask

    task automatic push_load(input logic [2:0] f, input int addr, input logic signed [31:0] v);
        t_voxel_req r;
        r = '{func: f, row: 6'($urandom), col: 4'($urandom), cidx: 12'($urandom),
              value: v, vx: 6'($urandom), vy: 6'($urandom), vz: 6'($urandom)};
        if (f == FUNC_LOAD_C) begin
            r.cidx = 12'(addr);
            wc[addr] = 1;
        end else begin
            r.row = 6'(addr / MAX_ORDER);
            r.col = 4'(addr % MAX_ORDER);
            if (f == FUNC_LOAD_X) wx[addr] = 1;
            else if (f == FUNC_LOAD_Y) wy[addr] = 1;
            else wz[addr] = 1;
        end
        push_req(r);
    endtask

    // load whatever the voxel needs that is still unwritten, then evaluate it
    task automatic push_eval(input logic [5:0] x, input logic [5:0] y, input logic [5:0] z);
        t_voxel_req r;
        int ox, oy, oz, ca;
        ox = eff_ord(ord_x);
        oy = eff_ord(ord_y);
        oz = eff_ord(ord_z);
        for (int i = 0; i < ox; i++)
            if (!wx[x*MAX_ORDER+i]) push_load(FUNC_LOAD_X, x*MAX_ORDER+i, rand_value());
        for (int j = 0; j < oy; j++)
            if (!wy[y*MAX_ORDER+j]) push_load(FUNC_LOAD_Y, y*MAX_ORDER+j, rand_value());
        for (int k = 0; k < oz; k++)
            if (!wz[z*MAX_ORDER+k]) push_load(FUNC_LOAD_Z, z*MAX_ORDER+k, rand_value());
        for (int k = 0; k < oz; k++)
            for (int j = 0; j < oy; j++)
                for (int i = 0; i < ox; i++) begin
                    ca = k*ox*oy + j*ox + i;
                    if (!wc[ca]) push_load(FUNC_LOAD_C, ca, rand_value());
                end
        r = '{func: FUNC_EVAL, row: 6'($urandom), col: 4'($urandom), cidx: 12'($urandom),
              value: $signed($urandom), vx: x, vy: y, vz: z};
        push_req(r);
    endtask

    task automatic push_noise();
        t_voxel_req r;
        r = '{func: 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
              row: 6'($urandom), col: 4'($urandom), cidx: 12'($urandom),
              value: $signed($urandom),
              vx: 6'($urandom), vy: 6'($urandom), vz: 6'($urandom)};
        push_req(r);
    endtask

    task automatic wait_drained();
        wait (pend_q.size() == 0 && !drv_valid && field_q.size() == 0);
        repeat (IDLE_LAT) @(negedge i_clk);
    endtask

    task automatic set_orders(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z);
        logic [4:0] v [3];
        logic [1:0] idx [3];
        v = '{x, y, z};
        idx = '{CFG_ORDER_X, CFG_ORDER_Y, CFG_ORDER_Z};
        wait_drained();
        for (int n = 0; n < 3; n++) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_idx <= idx[n];
            cfg_data <= v[n];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        ord_x = x;
        ord_y = y;
        ord_z = z;
    endtask

    // keep voxels to a few rows so basis loads stay bounded
    task automatic random_phase(input int n_items);
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(0, 9))
                0, 1: push_load(3'($urandom_range(FUNC_LOAD_X, FUNC_LOAD_C)),
                                $urandom_range(0, BASIS_DEPTH-1), rand_value());
                2: push_noise();
                default: push_eval(6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)),
                                   6'($urandom_range(0, 3)));
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at order one
        set_orders(5'd1, 5'd1, 5'd1);
        push_load(FUNC_LOAD_X, 0, 32'sh7fffffff);
        push_load(FUNC_LOAD_Y, 0, 32'sh7fffffff);
        push_load(FUNC_LOAD_Z, 0, 32'sh7fffffff);
        push_load(FUNC_LOAD_C, 0, 32'sh7fffffff);
        push_eval(6'd0, 6'd0, 6'd0);
        push_load(FUNC_LOAD_X, BASIS_DEPTH-MAX_ORDER, 32'sh80000000);
        push_load(FUNC_LOAD_Y, BASIS_DEPTH-MAX_ORDER, 32'sh7fffffff);
        push_load(FUNC_LOAD_Z, BASIS_DEPTH-MAX_ORDER, 32'sh00010000);
        push_eval(6'd63, 6'd63, 6'd63);
        push_load(FUNC_LOAD_C, 0, 32'sh00000000);
        push_eval(6'd63, 6'd63, 6'd0);
        push_load(FUNC_LOAD_X, BASIS_DEPTH-1, 32'sh00018000);
        push_load(FUNC_LOAD_C, COEF_DEPTH-1, 32'sh80000000);
        push_load(FUNC_LOAD_C, 0, 32'sh00010000);
        push_eval(6'd0, 6'd63, 6'd63);
        push_noise();
        push_noise();
        push_noise();

        // zero order gives an empty sum; above-maximum order clamps
        set_orders(5'd0, 5'd3, 5'd2);
        push_eval(6'($urandom), 6'($urandom), 6'($urandom));
        set_orders(5'd31, 5'd1, 5'd1);
        push_eval(6'($urandom), 6'($urandom), 6'($urandom));

        // mostly small orders
        for (int p = 0; p < 4; p++) begin
            set_orders(5'($urandom_range(1, 3)), 5'($urandom_range(1, 3)),
                       5'($urandom_range(1, 3)));
            random_phase(10);
            if (p == 1)
                hold_go = ~hold_go;
        end
        set_orders(5'($urandom_range(0, 3)), 5'd1, 5'($urandom_range(1, 3)));
        random_phase(6);

        wait_drained();
        repeat (IDLE_LAT) @(posedge i_clk);
        $display("covered %0d loads and %0d evaluations (%0d saturated)",
                 n_loads, n_evals, n_sat);
        $display("orders swept from 0 through 31 with clamping, plus a long receiver stall");
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
